// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is low.
`define AST_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is low.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/rdi_pkg.sv
`timescale 1ns / 1ps

package rdi_pkg;

    localparam int unsigned BUF_DEPTH = 65536;
    localparam int unsigned ADDR_W    = $clog2(BUF_DEPTH);
    localparam int unsigned SIZE_W    = 17;
    localparam int unsigned BYTE_W    = 8;

    localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = 17'h10000;
    localparam logic [BYTE_W-1:0] PRED_BIAS      = 8'h80;

    // Run decoder phase
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_LITERAL = 2'd1;
    localparam logic [1:0] PH_REPEAT  = 2'd2;

    // Sticky block error
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_OVERRUN = 2'd1;
    localparam logic [1:0] ERR_SRC_END = 2'd2;

    // Reported status
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_SRC_END   = 3'd2;
    localparam logic [2:0] STAT_SHORT     = 3'd3;
    localparam logic [2:0] STAT_NOT_READY = 3'd4;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    // Running predictor: first byte of a block passes unchanged.
    function automatic logic [BYTE_W-1:0] predict(input logic first,
                                                  input logic [BYTE_W-1:0] prev,
                                                  input logic [BYTE_W-1:0] d);
        logic [BYTE_W-1:0] p;
        p = first ? d : BYTE_W'(prev + d + PRED_BIAS);
        return p;
    endfunction

endpackage

// File: hw/rtl/rdi_store.sv
`timescale 1ns / 1ps

module rdi_store (
    input  logic                                i_clk,
    input  rdi_pkg::t_mem_req                   i_req,
    output logic [rdi_pkg::BYTE_W-1:0]          o_rdata
);

    logic [rdi_pkg::BYTE_W-1:0] r_mem [rdi_pkg::BUF_DEPTH];
    logic [rdi_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/rdi_cfg.sv
`timescale 1ns / 1ps

module rdi_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [rdi_pkg::SIZE_W-1:0]  o_block_size
);

    logic [rdi_pkg::SIZE_W-1:0] r_block_size;
    logic                       wr_en;

    // Byte lanes ignored; word 0 holds block_size.
    assign wr_en = psel && penable && pwrite && !paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= rdi_pkg::BLOCK_SIZE_RST;
        end else if (wr_en) begin
            r_block_size <= pwdata[rdi_pkg::SIZE_W-1:0];
        end
    end

    assign prdata       = paddr[2] ? 32'h0 : 32'(r_block_size);
    assign pready       = 1'b1;
    assign o_block_size = r_block_size;

endmodule

// File: hw/rtl/rle_delta_interleave_decoder.sv
`timescale 1ns / 1ps

// Run-length decoder with running byte predictor and two-half interleaved read-out.
// Items are issued on start while busy is low: i_req_type 0 pushes one compressed
// byte (i_in_last marks the end of the block), i_req_type 1 reads the next byte.
// Each result is shown for one cycle with o_valid high; the receiver cannot stall,
// so no result ever waits. Reads and pushes answer in the cycle after their beat,
// except a last-marked repeat value, whose status follows the run.
// A push without last gives no result. The push marked last gives a status
// result (o_is_status high): ok, overrun, source ended mid-run or size short.
// Reads return data bytes while the block is ready, else status "not ready".
// Rate: headers, literal bytes and reads are taken one per cycle while busy is low. The
// value byte of a repeat run writes one store entry per cycle, and busy stays high
// until the run is written; the single store write port sets this rate.
// block_size is written through the APB port at byte address 0; the user must write it only while idle (not enforced).
// Reset clears the control state and sets block_size to 65536; the decoded
// store is not cleared and needs no sweep, so items are taken right after reset.

module rle_delta_interleave_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_valid,
    output logic        o_is_status,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    output logic [2:0]  o_status
);

    localparam int unsigned SW = rdi_pkg::SIZE_W;
    localparam int unsigned AW = rdi_pkg::ADDR_W;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_REPEAT = 1'b1;

    logic          r_state,    n_state;
    logic [SW-1:0] r_wc,       n_wc;
    logic [7:0]    r_prev,     n_prev;
    logic [1:0]    r_phase,    n_phase;
    logic [7:0]    r_rem,      n_rem;
    logic [1:0]    r_err,      n_err;
    logic [SW-1:0] r_ri,       n_ri;
    logic          r_ready,    n_ready;
    logic [7:0]    r_rep_byte, n_rep_byte;
    logic          r_rep_last, n_rep_last;
    logic          r_valid,    n_valid;
    logic          r_is_status, n_is_status;
    logic          r_last,     n_last;
    logic [2:0]    r_status,   n_status;

    logic [SW-1:0]     block_size;
    logic [SW-1:0]     eff;
    logic [SW-1:0]     half;
    logic [SW-1:0]     rd_idx;
    logic [7:0]        put_byte;
    logic [7:0]        pred;
    logic [7:0]        hdr_count;
    logic              overrun;
    logic              accept;
    logic              finish;
    logic [2:0]        fin_status;
    logic [7:0]        rdata;
    rdi_pkg::t_mem_req mem_req;

    rdi_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_block_size (block_size)
    );

    rdi_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    assign busy   = (r_state == S_REPEAT);
    assign accept = start && !busy;

    assign eff = (32'(block_size) > rdi_pkg::BUF_DEPTH) ? SW'(rdi_pkg::BUF_DEPTH)
                                                        : block_size;
    assign half   = SW'(({1'b0, eff} + (SW+1)'(1)) >> 1);
    assign rd_idx = r_ri[0] ? SW'(half + (r_ri >> 1)) : (r_ri >> 1);

    assign put_byte  = (r_state == S_REPEAT) ? r_rep_byte : i_in_byte;
    assign pred      = rdi_pkg::predict(r_wc == '0, r_prev, put_byte);
    assign hdr_count = i_in_byte[7] ? 8'(~i_in_byte + 8'd1) : 8'(i_in_byte + 8'd1);
    assign overrun   = ({1'b0, r_wc} + (SW+1)'(hdr_count)) > {1'b0, eff};

    always_comb begin
        n_state     = r_state;
        n_wc        = r_wc;
        n_prev      = r_prev;
        n_phase     = r_phase;
        n_rem       = r_rem;
        n_err       = r_err;
        n_ri        = r_ri;
        n_ready     = r_ready;
        n_rep_byte  = r_rep_byte;
        n_rep_last  = r_rep_last;
        n_valid     = 1'b0;
        n_is_status = r_is_status;
        n_last      = r_last;
        n_status    = r_status;
        finish      = 1'b0;
        fin_status  = rdi_pkg::STAT_OK;
        mem_req     = '0;

        if (r_state == S_REPEAT) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = AW'(r_wc);
            mem_req.wdata = pred;
            n_wc          = SW'(r_wc + 1'b1);
            n_prev        = pred;
            n_rem         = 8'(r_rem - 8'd1);
            if (r_rem == 8'd1) begin
                n_phase = rdi_pkg::PH_HEADER;
                n_state = S_IDLE;
                finish  = r_rep_last;
            end
        end else if (accept) begin
            if (i_req_type) begin
                n_valid = 1'b1;
                if (!r_ready || r_ri >= eff) begin
                    n_ready     = 1'b0;
                    n_is_status = 1'b1;
                    n_last      = 1'b0;
                    n_status    = rdi_pkg::STAT_NOT_READY;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = AW'(rd_idx);
                    n_is_status   = 1'b0;
                    n_last        = (SW'(r_ri + 1'b1) == eff);
                    n_status      = rdi_pkg::STAT_OK;
                    n_ri          = SW'(r_ri + 1'b1);
                    if (SW'(r_ri + 1'b1) >= eff) begin
                        n_ready = 1'b0;
                    end
                end
            end else begin
                n_ready = 1'b0;
                finish  = i_in_last;
                // Once an error sticks, drop every byte until the last one.
                if (r_err == rdi_pkg::ERR_NONE) begin
                    unique case (r_phase)
                        rdi_pkg::PH_HEADER: begin
                            if (overrun) begin
                                n_err = rdi_pkg::ERR_OVERRUN;
                            end else begin
                                n_phase = i_in_byte[7] ? rdi_pkg::PH_LITERAL
                                                       : rdi_pkg::PH_REPEAT;
                                n_rem   = hdr_count;
                            end
                        end
                        rdi_pkg::PH_LITERAL: begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = AW'(r_wc);
                            mem_req.wdata = pred;
                            n_wc          = SW'(r_wc + 1'b1);
                            n_prev        = pred;
                            n_rem         = 8'(r_rem - 8'd1);
                            if (r_rem == 8'd1) begin
                                n_phase = rdi_pkg::PH_HEADER;
                            end
                        end
                        default: begin
                            // Repeat value: first entry now, the rest from S_REPEAT.
                            mem_req.we    = 1'b1;
                            mem_req.waddr = AW'(r_wc);
                            mem_req.wdata = pred;
                            n_wc          = SW'(r_wc + 1'b1);
                            n_prev        = pred;
                            n_rem         = 8'(r_rem - 8'd1);
                            if (r_rem == 8'd1) begin
                                n_phase = rdi_pkg::PH_HEADER;
                            end else begin
                                n_state    = S_REPEAT;
                                n_rep_byte = i_in_byte;
                                n_rep_last = i_in_last;
                                finish     = 1'b0;
                            end
                        end
                    endcase
                end
            end
        end

        if (finish) begin
            if (n_err == rdi_pkg::ERR_NONE && n_phase != rdi_pkg::PH_HEADER) begin
                fin_status = rdi_pkg::STAT_SRC_END;
            end else if (n_err == rdi_pkg::ERR_NONE && n_wc != eff) begin
                fin_status = rdi_pkg::STAT_SHORT;
            end else begin
                fin_status = 3'(n_err);
            end
            n_wc        = '0;
            n_phase     = rdi_pkg::PH_HEADER;
            n_rem       = '0;
            n_err       = rdi_pkg::ERR_NONE;
            n_ri        = '0;
            n_ready     = (fin_status == rdi_pkg::STAT_OK);
            n_valid     = 1'b1;
            n_is_status = 1'b1;
            n_last      = 1'b0;
            n_status    = fin_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wc        <= '0;
            r_prev      <= '0;
            r_phase     <= rdi_pkg::PH_HEADER;
            r_rem       <= '0;
            r_err       <= rdi_pkg::ERR_NONE;
            r_ri        <= '0;
            r_ready     <= 1'b0;
            r_rep_last  <= 1'b0;
            r_valid     <= 1'b0;
            r_is_status <= 1'b0;
            r_last      <= 1'b0;
            r_status    <= rdi_pkg::STAT_OK;
        end else begin
            r_state     <= n_state;
            r_wc        <= n_wc;
            r_prev      <= n_prev;
            r_phase     <= n_phase;
            r_rem       <= n_rem;
            r_err       <= n_err;
            r_ri        <= n_ri;
            r_ready     <= n_ready;
            r_rep_last  <= n_rep_last;
            r_valid     <= n_valid;
            r_is_status <= n_is_status;
            r_last      <= n_last;
            r_status    <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rep_byte <= n_rep_byte;
    end

    assign o_valid     = r_valid;
    assign o_is_status = r_is_status;
    assign o_out_last  = r_last;
    assign o_status    = r_status;
    // Read data comes straight from the store's output register.
    assign o_out_byte  = (r_valid && !r_is_status) ? rdata : 8'h00;

endmodule

// File: hw/rtl/rdi_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rdi_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_req_type,
    input logic       i_in_last,
    input logic       o_valid,
    input logic       o_is_status,
    input logic [7:0] o_out_byte,
    input logic       o_out_last,
    input logic [2:0] o_status
);

    `AST_IMPL(a_status_beat_clean, i_clk, i_rst_n, o_valid && o_is_status,
              o_out_byte == 8'h00 && !o_out_last, "status beat carries data")
    `AST_IMPL(a_data_beat_ok, i_clk, i_rst_n, o_valid && !o_is_status,
              o_status == rdi_pkg::STAT_OK, "data beat carries non-ok status")
    `AST_IMPL(a_status_range, i_clk, i_rst_n, o_valid,
              o_status <= rdi_pkg::STAT_NOT_READY, "status code out of range")
    `AST_NEXT(a_read_answers, i_clk, i_rst_n, start && !busy && i_req_type,
              o_valid, "read got no result")
    `AST_NEXT(a_push_silent, i_clk, i_rst_n, start && !busy && !i_req_type && !i_in_last,
              !o_valid, "plain push gave a result")

endmodule

bind rle_delta_interleave_decoder rdi_checker u_rdi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_req_type  (i_req_type),
    .i_in_last   (i_in_last),
    .o_valid     (o_valid),
    .o_is_status (o_is_status),
    .o_out_byte  (o_out_byte),
    .o_out_last  (o_out_last),
    .o_status    (o_status)
);

// File: tb/rle_delta_interleave_decoder_tb.sv
`timescale 1ns / 1ps

module rle_delta_interleave_decoder_tb;

    localparam logic       REQ_PUSH        = 1'b0;
    localparam logic       REQ_READ        = 1'b1;
    localparam logic [2:0] ADDR_BLOCK_SIZE = 3'd0;
    localparam int         TAIL_CYCLES     = 140;
    localparam int         ITEM_TARGET     = 1000;

    typedef struct packed {
        logic       req;
        logic [7:0] data;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic       is_status;
        logic [7:0] data;
        logic       last;
        logic [2:0] status;
    } t_reply;

    typedef enum int {BLK_OK, BLK_SHORT, BLK_OVERRUN, BLK_CUT, BLK_NOISE, BLK_REP} t_blk_kind;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start       = 1'b0;
    logic        busy;
    logic        i_req_type  = 1'b0;
    logic [7:0]  i_in_byte   = '0;
    logic        i_in_last   = 1'b0;
    logic        o_valid;
    logic        o_is_status;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic [2:0]  o_status;

    rle_delta_interleave_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start       (start),
        .busy        (busy),
        .i_req_type  (i_req_type),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_valid     (o_valid),
        .o_is_status (o_is_status),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_status    (o_status)
    );

    t_cmd   beats_pending[$];
    t_reply replies_due[$];

    // Decoder state as the testbench sees it
    logic [7:0]  store_img [rdi_pkg::BUF_DEPTH];
    int unsigned filled_len;
    int unsigned wr_cnt;
    logic [7:0]  prev_byte;
    logic [1:0]  phase;
    int unsigned run_left;
    logic [1:0]  err_code;
    int unsigned rd_pos;
    bit          blk_ready;
    int unsigned cfg_size;

    int          gap_max = 0;
    int          gap = 0;
    logic        beat_taken = 1'b0;
    int          errors = 0;
    int          n_items = 0;
    int          n_sizes = 0;
    int          bytes_read = 0;
    int          status_seen [5] = '{default: 0};

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_size();
        return (cfg_size < rdi_pkg::BUF_DEPTH) ? cfg_size : rdi_pkg::BUF_DEPTH;
    endfunction

    function automatic int unsigned interleave_pos(input int unsigned n, input int unsigned k);
        return k[0] ? (n + 1) / 2 + k / 2 : k / 2;
    endfunction

    function automatic void store_byte(input logic [7:0] d);
        logic [7:0] p;
        p = (wr_cnt == 0) ? d : 8'(prev_byte + d + rdi_pkg::PRED_BIAS);
        if (wr_cnt < rdi_pkg::BUF_DEPTH) begin
            store_img[wr_cnt] = p;
            if (wr_cnt + 1 > filled_len) filled_len = wr_cnt + 1;
        end
        prev_byte = p;
        wr_cnt++;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        int unsigned cnt;
        int unsigned room;
        if (err_code != rdi_pkg::ERR_NONE) return;
        case (phase)
            rdi_pkg::PH_HEADER: begin
                cnt  = b[7] ? 256 - int'(b) : int'(b) + 1;
                room = (wr_cnt < eff_size()) ? eff_size() - wr_cnt : 0;
                if (cnt > room) begin
                    err_code = rdi_pkg::ERR_OVERRUN;
                end else begin
                    phase    = b[7] ? rdi_pkg::PH_LITERAL : rdi_pkg::PH_REPEAT;
                    run_left = cnt;
                end
            end
            rdi_pkg::PH_LITERAL: begin
                store_byte(b);
                run_left--;
                if (run_left == 0) phase = rdi_pkg::PH_HEADER;
            end
            default: begin
                while (run_left != 0) begin
                    store_byte(b);
                    run_left--;
                end
                phase = rdi_pkg::PH_HEADER;
            end
        endcase
    endfunction

    // Advance the decoder state by one beat and queue the reply it owes
    function automatic void decode_step(input t_cmd c);
        logic [2:0]  st;
        int unsigned n;
        n = eff_size();
        if (c.req == REQ_PUSH) begin
            blk_ready = 1'b0;
            decode_byte(c.data);
            if (c.last) begin
                if (err_code == rdi_pkg::ERR_NONE && phase != rdi_pkg::PH_HEADER)
                    err_code = rdi_pkg::ERR_SRC_END;
                st = 3'(err_code);
                if (st == rdi_pkg::STAT_OK && wr_cnt != n) st = rdi_pkg::STAT_SHORT;
                wr_cnt    = 0;
                phase     = rdi_pkg::PH_HEADER;
                run_left  = 0;
                err_code  = rdi_pkg::ERR_NONE;
                rd_pos    = 0;
                blk_ready = (st == rdi_pkg::STAT_OK);
                replies_due.push_back('{1'b1, 8'h00, 1'b0, st});
            end
        end else if (!blk_ready || rd_pos >= n) begin
            blk_ready = 1'b0;
            replies_due.push_back('{1'b1, 8'h00, 1'b0, rdi_pkg::STAT_NOT_READY});
        end else begin
            replies_due.push_back('{1'b0, store_img[interleave_pos(n, rd_pos)],
                                    logic'(rd_pos + 1 == n), rdi_pkg::STAT_OK});
            rd_pos++;
            if (rd_pos >= n) blk_ready = 1'b0;
        end
    endfunction

    task automatic add_item(input logic req, input logic [7:0] data, input logic last);
        t_cmd c;
        c = '{req, data, last};
        beats_pending.push_back(c);
        decode_step(c);
        n_items++;
    endtask

    // Skip a read that would land on a store entry never written
    task automatic add_read();
        int unsigned n;
        n = eff_size();
        if (blk_ready && rd_pos < n && interleave_pos(n, rd_pos) >= filled_len) return;
        add_item(REQ_READ, 8'($urandom), 1'($urandom));
    endtask

    task automatic add_runs(ref logic [7:0] q[$], input int unsigned total,
                            input bit rep_only);
        int unsigned left;
        int unsigned cnt;
        int unsigned cap;
        left = total;
        while (left != 0) begin
            cap = (left < 128) ? left : 128;
            case ($urandom_range(0, 3))
                0:       cnt = cap;
                1:       cnt = 1;
                default: cnt = $urandom_range(1, cap);
            endcase
            if (rep_only) cnt = cap;
            if (!rep_only && $urandom_range(0, 1)) begin
                q.push_back(8'(256 - cnt));
                repeat (cnt) q.push_back(8'($urandom));
            end else begin
                q.push_back(8'(cnt - 1));
                q.push_back(8'($urandom));
            end
            left -= cnt;
        end
    endtask

    task automatic add_block(input int unsigned n, input t_blk_kind kind);
        logic [7:0]  q[$];
        int unsigned done_cnt;
        int unsigned room;
        int unsigned cnt;
        case (kind)
            BLK_OK:    add_runs(q, n, 1'b0);
            BLK_REP:   add_runs(q, n, 1'b1);
            BLK_SHORT: add_runs(q, $urandom_range(1, n - 1), 1'b0);
            BLK_OVERRUN: begin
                room = $urandom_range(0, (n < 127) ? n : 127);
                add_runs(q, n - room, 1'b0);
                cnt = $urandom_range(room + 1, 128);
                q.push_back($urandom_range(0, 1) ? 8'(256 - cnt) : 8'(cnt - 1));
                repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
            end
            BLK_CUT: begin
                done_cnt = $urandom_range(0, n - 1);
                add_runs(q, done_cnt, 1'b0);
                room = n - done_cnt;
                if (room > 128) room = 128;
                cnt = $urandom_range(1, room);
                if (cnt >= 2 && $urandom_range(0, 1)) begin
                    q.push_back(8'(256 - cnt));
                    repeat ($urandom_range(0, cnt - 1)) q.push_back(8'($urandom));
                end else begin
                    q.push_back($urandom_range(0, 1) ? 8'(256 - cnt) : 8'(cnt - 1));
                end
            end
            default: begin
                // raw noise: end the block at random points along the way
                repeat ($urandom_range(1, 12))
                    add_item(REQ_PUSH, 8'($urandom), $urandom_range(0, 5) == 0);
            end
        endcase
        foreach (q[i]) add_item(REQ_PUSH, q[i], i == q.size() - 1);
    endtask

    // Hold until the block has drained, then leave room for a trailing repeat run
    task automatic settle();
        while (beats_pending.size() != 0 || start || replies_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_block_size(input int unsigned size);
        logic [31:0] rd;
        apb_xfer(1'b1, ADDR_BLOCK_SIZE, 32'(size), rd);
        cfg_size = size & 32'h1FFFF;
        n_sizes++;
        apb_xfer(1'b0, ADDR_BLOCK_SIZE, '0, rd);
        if (rd !== 32'(cfg_size)) begin
            $error("block_size readback: expected %0d, got %0d", cfg_size, rd);
            errors++;
        end
    endtask

    always @(negedge i_clk) begin : drive
        t_cmd c;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || beat_taken) begin
            if (start) gap = $urandom_range(0, gap_max);
            if (gap != 0) begin
                gap--;
                start <= 1'b0;
            end else if (beats_pending.size() != 0) begin
                c = beats_pending.pop_front();
                i_req_type <= c.req;
                i_in_byte  <= c.data;
                i_in_last  <= c.last;
                start      <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            beat_taken <= 1'b0;
        end else begin
            beat_taken <= start && !busy;
            if (o_valid === 1'b1) begin
                if (replies_due.size() == 0) begin
                    $error("result with nothing expected: status %0d byte %0h",
                           o_status, o_out_byte);
                    errors++;
                end else begin
                    want = replies_due.pop_front();
                    if (o_is_status !== want.is_status) begin
                        $error("is_status: expected %0d, got %0d", want.is_status, o_is_status);
                        errors++;
                    end
                    if (o_out_byte !== want.data) begin
                        $error("out_byte: expected %0h, got %0h", want.data, o_out_byte);
                        errors++;
                    end
                    if (o_out_last !== want.last) begin
                        $error("out_last: expected %0d, got %0d", want.last, o_out_last);
                        errors++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        errors++;
                    end
                    if (want.is_status) status_seen[want.status]++;
                    else bytes_read++;
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned size;
        int unsigned nrd;
        t_blk_kind   kind;
        int          r;

        filled_len = 0;
        wr_cnt     = 0;
        prev_byte  = '0;
        phase      = rdi_pkg::PH_HEADER;
        run_left   = 0;
        err_code   = rdi_pkg::ERR_NONE;
        rd_pos     = 0;
        blk_ready  = 1'b0;
        cfg_size   = rdi_pkg::BLOCK_SIZE_RST;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // read before any block, headers that end the block, short block at full size
        add_read();
        add_item(REQ_PUSH, 8'h80, 1'b1);
        add_item(REQ_PUSH, 8'h7F, 1'b1);
        add_item(REQ_PUSH, 8'hFF, 1'b0);
        add_item(REQ_PUSH, 8'h00, 1'b0);
        add_item(REQ_PUSH, 8'h7F, 1'b0);
        add_item(REQ_PUSH, 8'hFF, 1'b1);
        settle();
        set_block_size(4);
        add_item(REQ_PUSH, 8'hFD, 1'b0);
        add_item(REQ_PUSH, 8'h10, 1'b0);
        add_item(REQ_PUSH, 8'h80, 1'b0);
        add_item(REQ_PUSH, 8'hFF, 1'b0);
        add_item(REQ_PUSH, 8'h00, 1'b0);
        add_item(REQ_PUSH, 8'h7F, 1'b1);
        repeat (5) add_read();
        add_item(REQ_PUSH, 8'h04, 1'b0);
        add_item(REQ_PUSH, 8'h00, 1'b1);
        settle();
        set_block_size(1);
        add_item(REQ_PUSH, 8'h00, 1'b0);
        add_item(REQ_PUSH, 8'hAB, 1'b1);
        repeat (2) add_read();
        add_item(REQ_PUSH, 8'hFE, 1'b0);
        add_item(REQ_PUSH, 8'h55, 1'b1);
        add_item(REQ_PUSH, 8'hFF, 1'b1);

        while (n_items < ITEM_TARGET) begin
            r = $urandom_range(0, 9);
            size = (r == 0) ? 1 : (r == 1) ? $urandom_range(100, 600) : $urandom_range(2, 48);
            settle();
            set_block_size(size);
            gap_max = $urandom_range(0, 1) ? 3 : 0;
            // reads straight after the size change may still see the old block
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) add_read();
            repeat ($urandom_range(3, 6)) begin
                r = $urandom_range(0, 9);
                kind = (r < 6) ? BLK_OK : (r == 6) ? BLK_SHORT : (r == 7) ? BLK_OVERRUN :
                       (r == 8) ? BLK_CUT : BLK_NOISE;
                if (kind == BLK_SHORT && size < 2) kind = BLK_OK;
                add_block(size, kind);
                nrd = (size <= 64) ? size + $urandom_range(0, 1) : $urandom_range(1, 40);
                if (kind != BLK_OK || $urandom_range(0, 4) == 0) nrd = $urandom_range(0, 3);
                repeat (nrd) add_read();
            end
        end

        // one full-size block built from maximal repeat runs, then a short one
        settle();
        set_block_size(65536);
        gap_max = 3;
        add_block(65536, BLK_REP);
        repeat (40) add_read();
        add_block($urandom_range(1, 4000), BLK_REP);
        add_read();

        settle();
        $display("%0d beats issued over %0d block sizes, %0d decoded bytes read back",
                 n_items, n_sizes, bytes_read);
        $display("block ends ok/overrun/cut/short: %0d/%0d/%0d/%0d, not-ready reads: %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (errors == 0) begin
            $display("rle_delta_interleave_decoder_tb passed");
        end else begin
            $display("rle_delta_interleave_decoder_tb failed");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("rle_delta_interleave_decoder_tb failed");
        $finish;
    end

endmodule
